@@ rtl/lzd_pkg.sv @@
// shared types, codes and constants of the lz token stream decoder
package lzd_pkg;

	// default sizes: the top level parameters and the command queue depth
	localparam int HISTORY_DEPTH_DEF = 65536;
	localparam int VALUE_BITS_DEF = 24;
	localparam int CMD_FIFO_DEPTH = 2;

	// transaction modes
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_ADVANCE = 1'b1;

	// header field maxima that call for an extension
	localparam logic [2:0] LRL_MAX = 3'd7;
	localparam logic [2:0] LEN_MAX = 3'd7;
	localparam logic [1:0] OFF_MAX = 2'd3;

	// radix code digit sizes and their thresholds
	localparam logic [2:0] LRL_BITS = 3'd1;
	localparam logic [2:0] LEN_BITS = 3'd2;
	localparam logic [2:0] OFF_BITS = 3'd4;
	localparam logic [7:0] LRL_THR = 8'(256 - (1 << LRL_BITS));
	localparam logic [7:0] LEN_THR = 8'(256 - (1 << LEN_BITS));
	localparam logic [7:0] OFF_THR = 8'(256 - (1 << OFF_BITS));

	// parser phases
	typedef enum logic [2:0] {
		PH_HEADER,
		PH_EXT_LRL,
		PH_EXT_LEN,
		PH_EXT_OFF,
		PH_LITERAL,
		PH_COPY
	} lzd_phase_t;

	// error codes
	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_ZERO_OFF,
		ERR_FAR_OFF,
		ERR_BUSY,
		ERR_TRUNC,
		ERR_OVERFLOW
	} lzd_err_t;

	// input transaction
	typedef struct packed {
		logic mode;
		logic [7:0] in_byte;
		logic final_byte;
	} lzd_token_t;

	// output transaction
	typedef struct packed {
		logic [7:0] data_byte;
		logic from_match;
		logic last_of_match;
		logic [2:0] error_code;
	} lzd_result_t;

	// command from the parser to the history back end
	typedef struct packed {
		logic wr;
		logic rd;
		logic last;
		logic [7:0] data;
		lzd_err_t err;
	} lzd_cmd_t;

endpackage

@@ rtl/lzd_front.sv @@
// token parser: header and extension decoding, copy sequencing, history pointers
module lzd_front #(
	parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF,
	parameter int VALUE_BITS = lzd_pkg::VALUE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic token_valid,
	output logic token_stall,
	input lzd_pkg::lzd_token_t token,
	input logic cmd_full,
	output logic cmd_push,
	output lzd_pkg::lzd_cmd_t cmd,
	output logic [$clog2(HISTORY_DEPTH)-1:0] cmd_src,
	output logic [$clog2(HISTORY_DEPTH)-1:0] cmd_wa
);
	import lzd_pkg::*;

	localparam int ADDR_W = $clog2(HISTORY_DEPTH);
	localparam int BW_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SH_W = $clog2(VALUE_BITS + 4);
	localparam int SW = VALUE_BITS + 8;
	localparam int CW = (VALUE_BITS > BW_W) ? VALUE_BITS : BW_W;
	localparam logic [BW_W-1:0] DEPTH_B = BW_W'(HISTORY_DEPTH);
	localparam logic [BW_W:0] DEPTH_E = (BW_W + 1)'(HISTORY_DEPTH);

	lzd_phase_t phase_q, phase_d;
	logic [VALUE_BITS-1:0] lit_q, lit_d;
	logic [VALUE_BITS-1:0] len_q, len_d;
	logic [VALUE_BITS-1:0] dist_q, dist_d;
	logic [SH_W-1:0] shift_q, shift_d;
	logic [ADDR_W-1:0] wpos_q, wpos_d, wpos_inc;
	logic [BW_W-1:0] bw_q, bw_d, bw_inc;

	logic accept;
	logic [VALUE_BITS-1:0] acc, acc_new;
	logic [2:0] dbits;
	logic [7:0] thr, digit;
	logic digit_last, dig_ovf;
	logic [SW-1:0] shifted;
	logic [SW:0] sum;
	logic [BW_W:0] src_raw, src_wrap;

	lzd_err_t err_d;
	logic emit, is_lit, is_copy, last;
	logic do_settle, chk_len, chk_off, do_start, clear;

	assign accept = token_valid && !cmd_full;
	assign token_stall = cmd_full;

	// extension digit unit shared by the three fields
	always_comb begin
		case (phase_q)
			PH_EXT_LEN: begin
				acc = len_q;
				dbits = LEN_BITS;
				thr = LEN_THR;
			end
			PH_EXT_OFF: begin
				acc = dist_q;
				dbits = OFF_BITS;
				thr = OFF_THR;
			end
			default: begin
				acc = lit_q;
				dbits = LRL_BITS;
				thr = LRL_THR;
			end
		endcase
		digit_last = token.in_byte < thr;
		digit = digit_last ? token.in_byte : token.in_byte - thr;
		shifted = SW'(digit) << shift_q;
		sum = (SW + 1)'(acc) + (SW + 1)'(shifted);
		dig_ovf = (shift_q >= SH_W'(VALUE_BITS)) || (sum[SW:VALUE_BITS] != '0);
		acc_new = sum[VALUE_BITS-1:0];
	end

	// history write pointer, fill level and copy source
	always_comb begin
		wpos_inc = ((BW_W'(wpos_q) + 1'b1) == DEPTH_B) ? '0 : wpos_q + 1'b1;
		bw_inc = (bw_q == DEPTH_B) ? bw_q : bw_q + 1'b1;
		src_raw = (BW_W + 1)'(wpos_q) + DEPTH_E - (BW_W + 1)'(dist_q);
		src_wrap = (src_raw >= DEPTH_E) ? src_raw - DEPTH_E : src_raw;
	end

	// parse step for one transaction
	always_comb begin
		phase_d = phase_q;
		lit_d = lit_q;
		len_d = len_q;
		dist_d = dist_q;
		shift_d = shift_q;
		wpos_d = wpos_q;
		bw_d = bw_q;
		err_d = ERR_NONE;
		emit = 1'b0;
		is_lit = 1'b0;
		is_copy = 1'b0;
		last = 1'b0;
		do_settle = 1'b0;
		chk_len = 1'b0;
		chk_off = 1'b0;
		do_start = 1'b0;
		clear = 1'b0;
		if (token.mode == MODE_ADVANCE) begin
			// one byte of a pending match copy
			if (phase_q == PH_COPY) begin
				emit = 1'b1;
				is_copy = 1'b1;
				wpos_d = wpos_inc;
				bw_d = bw_inc;
				len_d = len_q - 1'b1;
				last = (len_q == VALUE_BITS'(1));
				clear = last;
			end
		end else begin
			case (phase_q)
				PH_COPY: begin
					err_d = ERR_BUSY;
				end
				PH_HEADER: begin
					lit_d = VALUE_BITS'(token.in_byte[7:5]);
					len_d = VALUE_BITS'(token.in_byte[4:2]);
					dist_d = VALUE_BITS'(token.in_byte[1:0]);
					if (token.in_byte[7:5] == LRL_MAX) begin
						phase_d = PH_EXT_LRL;
						shift_d = '0;
					end else begin
						do_settle = 1'b1;
						chk_len = 1'b1;
						chk_off = 1'b1;
					end
				end
				PH_EXT_LRL: begin
					if (dig_ovf) begin
						err_d = ERR_OVERFLOW;
					end else begin
						lit_d = acc_new;
						if (digit_last) begin
							do_settle = 1'b1;
							chk_len = 1'b1;
							chk_off = 1'b1;
						end else begin
							shift_d = shift_q + SH_W'(dbits);
						end
					end
				end
				PH_EXT_LEN: begin
					if (dig_ovf) begin
						err_d = ERR_OVERFLOW;
					end else begin
						len_d = acc_new;
						if (digit_last) begin
							do_settle = 1'b1;
							chk_off = 1'b1;
						end else begin
							shift_d = shift_q + SH_W'(dbits);
						end
					end
				end
				PH_EXT_OFF: begin
					if (dig_ovf) begin
						err_d = ERR_OVERFLOW;
					end else begin
						dist_d = acc_new;
						if (digit_last) begin
							do_settle = 1'b1;
						end else begin
							shift_d = shift_q + SH_W'(dbits);
						end
					end
				end
				PH_LITERAL: begin
					is_lit = 1'b1;
					wpos_d = wpos_inc;
					bw_d = bw_inc;
					if (lit_q != '0) begin
						lit_d = lit_q - 1'b1;
					end
					do_start = (lit_d == '0);
				end
				default: begin
					clear = 1'b1;
				end
			endcase

			// move on to the next field that needs an extension, else to the literals or the match
			if (do_settle) begin
				if (chk_len && len_d == VALUE_BITS'(LEN_MAX)) begin
					phase_d = PH_EXT_LEN;
					shift_d = '0;
				end else if (chk_off && dist_d == VALUE_BITS'(OFF_MAX)) begin
					phase_d = PH_EXT_OFF;
					shift_d = '0;
				end else if (lit_d != '0) begin
					phase_d = PH_LITERAL;
				end else begin
					do_start = 1'b1;
				end
			end

			// check the match before copying
			if (do_start) begin
				if (len_d == '0) begin
					clear = 1'b1;
				end else if (dist_d == '0) begin
					err_d = ERR_ZERO_OFF;
					clear = 1'b1;
				end else if (CW'(dist_d) > CW'(bw_d)) begin
					err_d = ERR_FAR_OFF;
					clear = 1'b1;
				end else begin
					phase_d = PH_COPY;
				end
			end

			if (err_d == ERR_OVERFLOW) begin
				clear = 1'b1;
			end

			// stream ended while bytes are still owed
			if (err_d == ERR_NONE && token.final_byte && !clear &&
				(phase_d == PH_EXT_LRL || phase_d == PH_EXT_LEN ||
				 phase_d == PH_EXT_OFF || phase_d == PH_LITERAL)) begin
				err_d = ERR_TRUNC;
				clear = 1'b1;
			end

			emit = is_lit || (err_d != ERR_NONE);
		end

		if (clear) begin
			phase_d = PH_HEADER;
			lit_d = '0;
			len_d = '0;
			dist_d = '0;
			shift_d = '0;
		end
	end

	// command toward the back end
	always_comb begin
		cmd_push = accept && emit;
		cmd.wr = is_lit || is_copy;
		cmd.rd = is_copy;
		cmd.last = last;
		cmd.data = is_lit ? token.in_byte : 8'd0;
		cmd.err = err_d;
		cmd_src = src_wrap[ADDR_W-1:0];
		cmd_wa = wpos_q;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			lit_q <= '0;
			len_q <= '0;
			dist_q <= '0;
			shift_q <= '0;
			wpos_q <= '0;
			bw_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			lit_q <= lit_d;
			len_q <= len_d;
			dist_q <= dist_d;
			shift_q <= shift_d;
			wpos_q <= wpos_d;
			bw_q <= bw_d;
		end
	end

	// a pending copy always has bytes left and a source inside the history
	a_copy_sane: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_COPY |-> len_q != '0 && dist_q != '0 && CW'(dist_q) <= CW'(bw_q))
		else $error("copy pending with invalid length or distance");

	// the last copied byte returns the parser to header
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push && cmd.last |=> phase_q == PH_HEADER)
		else $error("parser not back at header after last match byte");

endmodule

@@ rtl/lzd_cmd_fifo.sv @@
// small command queue between the parser and the history back end
module lzd_cmd_fifo #(
	parameter int WIDTH = 16,
	parameter int DEPTH = lzd_pkg::CMD_FIFO_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] wdata,
	output logic full,
	input logic pop,
	output logic head_valid,
	output logic [WIDTH-1:0] head
);
	import lzd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head = slot_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("command queue popped while empty");

	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push) && !$past(pop))
		else $error("command queue became full without a push");

endmodule

@@ rtl/lzd_back.sv @@
// history back end: ring memory, copy read with forwarding, output register
module lzd_back #(
	parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input lzd_pkg::lzd_cmd_t head_cmd,
	input logic [$clog2(HISTORY_DEPTH)-1:0] head_src,
	input logic [$clog2(HISTORY_DEPTH)-1:0] head_wa,
	output logic pop,
	output logic data_valid,
	input logic data_stall,
	output lzd_pkg::lzd_result_t data
);
	import lzd_pkg::*;

	localparam int ADDR_W = $clog2(HISTORY_DEPTH);

	logic [7:0] hist_mem [HISTORY_DEPTH];

	logic valid_s1;
	lzd_cmd_t cmd_s1;
	logic [ADDR_W-1:0] wa_s1;
	logic [7:0] rd_s1, fwd_data_s1, byte_s1;
	logic fwd_s1;
	logic adv_s1;

	logic valid_q;
	lzd_result_t result_q;

	// stage advance and queue pop
	assign adv_s1 = valid_s1 && (!valid_q || !data_stall);
	assign pop = head_valid && (!valid_s1 || adv_s1);

	// byte of this transaction: forwarded, read from history, or literal
	assign byte_s1 = cmd_s1.rd ? (fwd_s1 ? fwd_data_s1 : rd_s1) : cmd_s1.data;

	// history ring
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_s1 <= hist_mem[head_src];
		end
		if (adv_s1 && cmd_s1.wr) begin
			hist_mem[wa_s1] <= byte_s1;
		end
	end

	// stage payload, catching a read of the byte written in the same cycle
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= head_cmd;
			wa_s1 <= head_wa;
			fwd_s1 <= adv_s1 && cmd_s1.wr && (wa_s1 == head_src);
			fwd_data_s1 <= byte_s1;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q.data_byte <= byte_s1;
			result_q.from_match <= cmd_s1.rd;
			result_q.last_of_match <= cmd_s1.last;
			result_q.error_code <= cmd_s1.err;
		end
	end

	// stage and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_q <= 1'b1;
			end else if (!data_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign data_valid = valid_q;
	assign data = result_q;

	a_copy_writes: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && cmd_s1.rd |-> cmd_s1.wr && cmd_s1.err == ERR_NONE)
		else $error("copy command without history write or with error");

	a_out_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(data_valid) |-> $past(adv_s1))
		else $error("output valid without a stage advance");

endmodule

@@ rtl/lz_token_stream_decoder.sv @@
// top level of the lz token stream decoder
// Decodes an LZ77 byte-token stream: mode 0 transactions deliver compressed
// bytes, mode 1 transactions advance a pending match copy by one byte. The
// block takes one transaction per clock in either mode while the command
// queue is not full, and gives at most one result per transaction: the
// parser decodes the transaction and pushes its command into the queue as it
// accepts it, then the command passes from the queue through the registered
// history read into the output register. The rate is
// set by the parser, which decodes a header or extension byte, or issues one
// copy command, per clock, and by the single history ring with one read and
// one write port; a copy whose source is the byte written just before is
// forwarded around the ring. token_stall rises only while the two-entry
// command queue is full. The history ring has no reset and no clearing pass:
// offsets are checked against the bytes written.
module lz_token_stream_decoder #(
	parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF,
	parameter int VALUE_BITS = lzd_pkg::VALUE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic token_valid,
	output logic token_stall,
	input lzd_pkg::lzd_token_t token,
	output logic data_valid,
	input logic data_stall,
	output lzd_pkg::lzd_result_t data
);
	import lzd_pkg::*;

	localparam int ADDR_W = $clog2(HISTORY_DEPTH);
	localparam int CMD_W = $bits(lzd_cmd_t) + 2 * ADDR_W;

	logic cmd_push, cmd_full, head_valid, pop;
	lzd_cmd_t cmd, head_cmd;
	logic [ADDR_W-1:0] cmd_src, cmd_wa, head_src, head_wa;
	logic [CMD_W-1:0] head_bits;

	// parser
	lzd_front #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token(token),
		.cmd_full(cmd_full),
		.cmd_push(cmd_push),
		.cmd(cmd),
		.cmd_src(cmd_src),
		.cmd_wa(cmd_wa)
	);

	// command queue
	lzd_cmd_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(CMD_FIFO_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.wdata({cmd, cmd_src, cmd_wa}),
		.full(cmd_full),
		.pop(pop),
		.head_valid(head_valid),
		.head(head_bits)
	);

	assign {head_cmd, head_src, head_wa} = head_bits;

	// history back end
	lzd_back #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_cmd(head_cmd),
		.head_src(head_src),
		.head_wa(head_wa),
		.pop(pop),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data(data)
	);

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the lz token stream decoder
module testbench;
	import lzd_pkg::*;

	localparam int HIST_DEPTH = HISTORY_DEPTH_DEF;
	localparam int VALUE_BITS = VALUE_BITS_DEF;
	localparam longint unsigned FIELD_MAX = (64'd1 << VALUE_BITS) - 64'd1;
	localparam int GEN_TRACK = 0;
	localparam int EXPECT_TRACK = 1;
	localparam int ITEMS_PER_PHASE = 350;
	localparam int HOLD_CYCLES = 120;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum logic [1:0] {
		DIGIT_MORE,
		DIGIT_LAST,
		DIGIT_OVF
	} digit_t;

	// decoder state kept by the prediction, one copy per track
	typedef struct packed {
		lzd_phase_t phase;
		logic [31:0] lit_left;
		logic [31:0] copy_left;
		logic [31:0] copy_dist;
		logic [7:0] shift;
		logic [31:0] wr_pos;
		logic [31:0] written;
	} parse_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic token_valid = 1'b0;
	logic token_stall;
	lzd_token_t token = '0;
	logic data_valid;
	logic data_stall = 1'b0;
	lzd_result_t data;

	parse_state_t parse_st [2];
	logic [7:0] history [2][HIST_DEPTH];
	logic [7:0] plan_bytes [$];
	lzd_token_t pending_tokens [$];
	lzd_result_t expected_bytes [$];
	lzd_result_t predicted;
	int items_queued = 0;
	int failures = 0;
	int send_idle_pct = 19;
	int recv_idle_pct = 73;
	logic hold_armed = 1'b0;
	logic hold_done;
	int hold_left;
	int idle_cycles = 0;

	lz_token_stream_decoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token(token),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data(data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	// drop the current token and wait for a header
	function automatic void clear_token(int k);
		parse_st[k].lit_left = '0;
		parse_st[k].copy_left = '0;
		parse_st[k].copy_dist = '0;
		parse_st[k].shift = '0;
		parse_st[k].phase = PH_HEADER;
	endfunction

	// append one output byte to the history ring
	function automatic void record_byte(int k, logic [7:0] v);
		history[k][parse_st[k].wr_pos] = v;
		parse_st[k].wr_pos = (parse_st[k].wr_pos + 1) % HIST_DEPTH;
		if (parse_st[k].written < HIST_DEPTH)
			parse_st[k].written = parse_st[k].written + 1;
	endfunction

	// one radix digit of an extension value
	function automatic digit_t add_digit(int k, inout logic [31:0] acc,
			input logic [2:0] bits, input logic [7:0] thr, input logic [7:0] b);
		longint unsigned sum;
		int unsigned digit;
		digit = (b < thr) ? b : b - thr;
		if (parse_st[k].shift >= VALUE_BITS)
			return DIGIT_OVF;
		sum = 64'(acc) + (64'(digit) << parse_st[k].shift);
		if (sum > FIELD_MAX)
			return DIGIT_OVF;
		acc = sum[31:0];
		if (b < thr)
			return DIGIT_LAST;
		parse_st[k].shift = parse_st[k].shift + 8'(bits);
		return DIGIT_MORE;
	endfunction

	// offset checks once all literals are in
	function automatic lzd_err_t begin_match(int k);
		if (parse_st[k].copy_left == 0) begin
			clear_token(k);
			return ERR_NONE;
		end
		if (parse_st[k].copy_dist == 0) begin
			clear_token(k);
			return ERR_ZERO_OFF;
		end
		if (parse_st[k].copy_dist > parse_st[k].written) begin
			clear_token(k);
			return ERR_FAR_OFF;
		end
		parse_st[k].phase = PH_COPY;
		return ERR_NONE;
	endfunction

	// pick the next field that still owes an extension
	function automatic lzd_err_t next_field(int k, lzd_phase_t from);
		if (from <= PH_EXT_LEN && parse_st[k].copy_left == LEN_MAX) begin
			parse_st[k].phase = PH_EXT_LEN;
			parse_st[k].shift = '0;
			return ERR_NONE;
		end
		if (from <= PH_EXT_OFF && parse_st[k].copy_dist == OFF_MAX) begin
			parse_st[k].phase = PH_EXT_OFF;
			parse_st[k].shift = '0;
			return ERR_NONE;
		end
		if (parse_st[k].lit_left != 0) begin
			parse_st[k].phase = PH_LITERAL;
			return ERR_NONE;
		end
		return begin_match(k);
	endfunction

	// decode one transaction, returns 1 when it yields a result
	function automatic bit decode_step(int k, lzd_token_t t, output lzd_result_t r);
		lzd_err_t err;
		digit_t d;
		logic [31:0] acc;
		logic [31:0] src;
		logic [7:0] v;
		bit lit;
		err = ERR_NONE;
		lit = 1'b0;
		r = '0;

		// match copy advance
		if (t.mode == MODE_ADVANCE) begin
			if (parse_st[k].phase != PH_COPY || parse_st[k].copy_left == 0 ||
					parse_st[k].copy_dist == 0 ||
					parse_st[k].copy_dist > parse_st[k].written)
				return 1'b0;
			src = (parse_st[k].wr_pos + HIST_DEPTH - parse_st[k].copy_dist) % HIST_DEPTH;
			v = history[k][src];
			record_byte(k, v);
			parse_st[k].copy_left = parse_st[k].copy_left - 1;
			r.data_byte = v;
			r.from_match = 1'b1;
			r.last_of_match = (parse_st[k].copy_left == 0);
			if (parse_st[k].copy_left == 0)
				clear_token(k);
			return 1'b1;
		end

		// compressed byte
		case (parse_st[k].phase)
			PH_COPY: begin
				r.error_code = ERR_BUSY;
				return 1'b1;
			end
			PH_HEADER: begin
				parse_st[k].lit_left = 32'(t.in_byte[7:5]);
				parse_st[k].copy_left = 32'(t.in_byte[4:2]);
				parse_st[k].copy_dist = 32'(t.in_byte[1:0]);
				if (parse_st[k].lit_left == LRL_MAX) begin
					parse_st[k].phase = PH_EXT_LRL;
					parse_st[k].shift = '0;
				end else begin
					err = next_field(k, PH_EXT_LEN);
				end
			end
			PH_EXT_LRL: begin
				acc = parse_st[k].lit_left;
				d = add_digit(k, acc, LRL_BITS, LRL_THR, t.in_byte);
				parse_st[k].lit_left = acc;
				if (d == DIGIT_OVF)
					err = ERR_OVERFLOW;
				else if (d == DIGIT_LAST)
					err = next_field(k, PH_EXT_LEN);
			end
			PH_EXT_LEN: begin
				acc = parse_st[k].copy_left;
				d = add_digit(k, acc, LEN_BITS, LEN_THR, t.in_byte);
				parse_st[k].copy_left = acc;
				if (d == DIGIT_OVF)
					err = ERR_OVERFLOW;
				else if (d == DIGIT_LAST)
					err = next_field(k, PH_EXT_OFF);
			end
			PH_EXT_OFF: begin
				acc = parse_st[k].copy_dist;
				d = add_digit(k, acc, OFF_BITS, OFF_THR, t.in_byte);
				parse_st[k].copy_dist = acc;
				if (d == DIGIT_OVF)
					err = ERR_OVERFLOW;
				else if (d == DIGIT_LAST)
					err = next_field(k, PH_LITERAL);
			end
			PH_LITERAL: begin
				record_byte(k, t.in_byte);
				lit = 1'b1;
				if (parse_st[k].lit_left != 0)
					parse_st[k].lit_left = parse_st[k].lit_left - 1;
				if (parse_st[k].lit_left == 0)
					err = begin_match(k);
			end
			default: begin
				clear_token(k);
				return 1'b0;
			end
		endcase

		// overflow drops the token, truncation only if nothing else went wrong
		if (err == ERR_OVERFLOW)
			clear_token(k);
		if (err == ERR_NONE && t.final_byte && (parse_st[k].phase == PH_EXT_LRL ||
				parse_st[k].phase == PH_EXT_LEN || parse_st[k].phase == PH_EXT_OFF ||
				parse_st[k].phase == PH_LITERAL)) begin
			err = ERR_TRUNC;
			clear_token(k);
		end
		if (lit || err != ERR_NONE) begin
			r.data_byte = lit ? t.in_byte : 8'h00;
			r.error_code = err;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// ---------------------------------------------------------------
	// stimulus generation
	// ---------------------------------------------------------------

	// queue one transaction and track the decoder state it leads to
	function automatic void queue_item(logic mode, logic [7:0] b, logic fin);
		lzd_token_t t;
		lzd_result_t ignored;
		t.mode = mode;
		t.in_byte = b;
		t.final_byte = fin;
		if (decode_step(GEN_TRACK, t, ignored) || mode == MODE_BYTE)
			items_queued++;
		pending_tokens.push_back(t);
	endfunction

	function automatic void queue_advance();
		queue_item(MODE_ADVANCE, 8'($urandom), 1'($urandom));
	endfunction

	// radix code of an extension value, sometimes with redundant digits
	function automatic void plan_ext(int unsigned value, logic [2:0] bits, logic [7:0] thr);
		int unsigned rest;
		int unsigned d;
		rest = value;
		while (rest >= thr || (rest != 0 && $urandom_range(3) == 0)) begin
			d = rest % (1 << bits);
			plan_bytes.push_back(8'(thr + d));
			rest = (rest - d) >> bits;
		end
		plan_bytes.push_back(8'(rest));
	endfunction

	// header, extensions and literals of one token
	function automatic void plan_token(int unsigned lit, int unsigned len, int unsigned off);
		logic [7:0] hdr;
		plan_bytes.delete();
		hdr[7:5] = (lit >= LRL_MAX) ? LRL_MAX : 3'(lit);
		hdr[4:2] = (len >= LEN_MAX) ? LEN_MAX : 3'(len);
		hdr[1:0] = (off >= OFF_MAX) ? OFF_MAX : 2'(off);
		plan_bytes.push_back(hdr);
		if (lit >= LRL_MAX)
			plan_ext(lit - LRL_MAX, LRL_BITS, LRL_THR);
		if (len >= LEN_MAX)
			plan_ext(len - LEN_MAX, LEN_BITS, LEN_THR);
		if (off >= OFF_MAX)
			plan_ext(off - OFF_MAX, OFF_BITS, OFF_THR);
		repeat (lit)
			plan_bytes.push_back(8'($urandom));
	endfunction

	// copy out any pending match, cut anything else short, back to a header
	function automatic void drain_to_header();
		while (parse_st[GEN_TRACK].phase != PH_HEADER) begin
			if (parse_st[GEN_TRACK].phase != PH_COPY)
				queue_item(MODE_BYTE, 8'h00, 1'b1);
			else if ($urandom_range(24) == 0)
				queue_item(MODE_BYTE, 8'($urandom), 1'($urandom));
			else
				queue_advance();
		end
	endfunction

	// a field extended with continuation digits until it overflows or ends
	function automatic void queue_overflow_token();
		logic [7:0] hdr;
		logic [7:0] thr;
		lzd_phase_t ext_phase;
		hdr = {3'($urandom_range(6)), 3'($urandom_range(6)), 2'($urandom_range(2))};
		case ($urandom_range(2))
			0: begin
				hdr[7:5] = LRL_MAX;
				thr = LRL_THR;
				ext_phase = PH_EXT_LRL;
			end
			1: begin
				// no offset, so a huge length ends in a zero offset
				hdr[4:2] = LEN_MAX;
				hdr[1:0] = 2'd0;
				thr = LEN_THR;
				ext_phase = PH_EXT_LEN;
			end
			default: begin
				hdr[1:0] = OFF_MAX;
				thr = OFF_THR;
				ext_phase = PH_EXT_OFF;
			end
		endcase
		queue_item(MODE_BYTE, hdr, 1'b0);
		while (parse_st[GEN_TRACK].phase == ext_phase) begin
			if ($urandom_range(15) == 0 && parse_st[GEN_TRACK].shift >= VALUE_BITS / 2)
				queue_item(MODE_BYTE, 8'($urandom_range(thr - 1)), 1'b0);
			else
				queue_item(MODE_BYTE, 8'($urandom_range(255, thr)), 1'b0);
		end
	endfunction

	// one random token, mostly well formed
	function automatic void queue_random_token();
		int unsigned kind;
		int unsigned pick;
		int unsigned lit;
		int unsigned len;
		int unsigned off;
		int unsigned w;
		int unsigned n;
		logic fin_last;
		kind = $urandom_range(99);
		if (kind < 5) begin
			queue_advance();
			return;
		end
		if (kind < 10) begin
			queue_overflow_token();
			drain_to_header();
			return;
		end
		pick = $urandom_range(99);
		lit = (pick < 70) ? $urandom_range(6) :
			(pick < 95) ? $urandom_range(20, 7) : $urandom_range(80, 21);
		pick = $urandom_range(99);
		len = (pick < 10) ? 0 : (pick < 60) ? $urandom_range(6, 1) :
			(pick < 95) ? $urandom_range(30, 7) : $urandom_range(200, 31);
		w = parse_st[GEN_TRACK].written + lit;
		if (w > HIST_DEPTH)
			w = HIST_DEPTH;
		if (kind < 14)
			off = 0;
		else if (kind < 18)
			off = w + 1 + $urandom_range(300);
		else if (w == 0)
			off = $urandom_range(3);
		else if ($urandom_range(1) == 0)
			off = $urandom_range((w < 20) ? w : 20, 1);
		else
			off = $urandom_range(w, 1);
		plan_token(lit, len, off);
		n = plan_bytes.size();
		fin_last = ($urandom_range(4) == 0);
		// truncated token
		if (kind < 26 && n > 1) begin
			n = $urandom_range(n - 1, 1);
			fin_last = 1'b1;
		end
		for (int i = 0; i < n; i++)
			queue_item(MODE_BYTE, plan_bytes[i], fin_last && i == n - 1);
		drain_to_header();
	endfunction

	// ---------------------------------------------------------------
	// driver: offers queued tokens and predicts at acceptance
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_valid <= 1'b0;
		end else begin
			if (token_valid && !token_stall) begin
				if (decode_step(EXPECT_TRACK, token, predicted))
					expected_bytes.push_back(predicted);
			end
			if (!token_valid || !token_stall) begin
				if (pending_tokens.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					token <= pending_tokens.pop_front();
					token_valid <= 1'b1;
				end else begin
					token_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: checks each output transaction and drives the stall
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		lzd_result_t want;
		if (!arst_n) begin
			data_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (data_valid && !data_stall) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected result: data_byte %0d error_code %0d",
						data.data_byte, data.error_code);
					failures++;
				end else begin
					want = expected_bytes.pop_front();
					if (data.data_byte !== want.data_byte) begin
						$error("data_byte: expected %0d, actual %0d",
							want.data_byte, data.data_byte);
						failures++;
					end
					if (data.from_match !== want.from_match) begin
						$error("from_match: expected %0d, actual %0d",
							want.from_match, data.from_match);
						failures++;
					end
					if (data.last_of_match !== want.last_of_match) begin
						$error("last_of_match: expected %0d, actual %0d",
							want.last_of_match, data.last_of_match);
						failures++;
					end
					if (data.error_code !== want.error_code) begin
						$error("error_code: expected %0d, actual %0d",
							want.error_code, data.error_code);
						failures++;
					end
				end
			end
			// long hold-off once so the block backs up, otherwise random stalls
			if (hold_left != 0) begin
				data_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (hold_armed && !hold_done) begin
				data_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				data_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// watchdog on cycles without any transaction while work is outstanding
	always @(posedge clk) begin
		if ((token_valid && !token_stall) || (data_valid && !data_stall) ||
				(pending_tokens.size() == 0 && !token_valid && expected_bytes.size() == 0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// sequence: reset, directed tokens, three random phases, drain
	// ---------------------------------------------------------------
	initial begin
		for (int k = 0; k < 2; k++) begin
			clear_token(k);
			parse_st[k].wr_pos = '0;
			parse_st[k].written = '0;
		end

		// advance with nothing to copy, then an empty header marked final
		queue_advance();
		queue_item(MODE_BYTE, 8'h00, 1'b1);
		// two literals at the byte extremes
		queue_item(MODE_BYTE, 8'h40, 1'b0);
		queue_item(MODE_BYTE, 8'hFF, 1'b0);
		queue_item(MODE_BYTE, 8'h00, 1'b0);
		// match left pending after the final byte, a byte during the copy
		queue_item(MODE_BYTE, 8'h09, 1'b1);
		queue_item(MODE_BYTE, 8'hA5, 1'b0);
		queue_advance();
		queue_advance();
		// zero offset
		queue_item(MODE_BYTE, 8'h04, 1'b0);
		// offset beyond history, reported on the literal
		queue_item(MODE_BYTE, 8'h2F, 1'b0);
		queue_item(MODE_BYTE, 8'd100, 1'b0);
		queue_item(MODE_BYTE, 8'h5A, 1'b0);
		// empty match with a zero offset is fine
		queue_item(MODE_BYTE, 8'h20, 1'b0);
		queue_item(MODE_BYTE, 8'hC3, 1'b0);
		// truncated on a literal
		queue_item(MODE_BYTE, 8'h40, 1'b0);
		queue_item(MODE_BYTE, 8'h11, 1'b1);
		// offset extension overflowing its value range
		queue_item(MODE_BYTE, 8'h03, 1'b0);
		repeat (5)
			queue_item(MODE_BYTE, 8'hFF, 1'b0);
		queue_item(MODE_BYTE, 8'hEF, 1'b0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 73;
				end
				1: begin
					send_idle_pct = 73;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_armed = 1'b1;
				end
			endcase
			while (items_queued < (p + 1) * ITEMS_PER_PHASE)
				queue_random_token();
			while (pending_tokens.size() != 0)
				@(posedge clk);
		end

		// wait for the last transaction and the results still owed
		while (token_valid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (failures == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ lz_token_stream_decoder.f @@
rtl/lzd_pkg.sv
rtl/lzd_front.sv
rtl/lzd_cmd_fifo.sv
rtl/lzd_back.sv
rtl/lz_token_stream_decoder.sv
tb/testbench.sv
